@@ hw/rtl/gb3_pkg.sv @@
package gb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;

    localparam int IMAGE_WIDTH_RST  = 1024;
    localparam int IMAGE_HEIGHT_RST = 768;
    localparam int MIN_DIM          = 3;

    localparam int CHAN_W    = 8;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 10;
    localparam int N_RES     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    localparam int PIX_W = $bits(t_pixel);

    typedef struct packed {
        t_pixel                pixel;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_COL_W-1:0]  column;
        logic                  frame_done;
    } t_result;

endpackage

@@ hw/rtl/gb3_ram.sv @@
module gb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/gb3_blur.sv @@
module gb3_blur (
    input  gb3_pkg::t_pixel [5:0] i_win,
    input  gb3_pkg::t_pixel [2:0] i_cur,
    output gb3_pkg::t_pixel       o_pix
);

    localparam int CW = gb3_pkg::CHAN_W;
    localparam int SW = CW + 4;

    logic [gb3_pkg::PIX_W-1:0] pix;

    always_comb begin
        logic [SW-1:0] row_sum [3];
        logic [SW-1:0] sum;
        logic [gb3_pkg::PIX_W-1:0] w_a;
        logic [gb3_pkg::PIX_W-1:0] w_b;
        logic [gb3_pkg::PIX_W-1:0] w_d;
        pix = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                w_a = i_win[2 * i];
                w_b = i_win[2 * i + 1];
                w_d = i_cur[i];
                row_sum[i] = SW'(w_a[ch * CW +: CW]) + (SW'(w_b[ch * CW +: CW]) << 1)
                           + SW'(w_d[ch * CW +: CW]);
            end
            sum = row_sum[0] + (row_sum[1] << 1) + row_sum[2];
            pix[ch * CW +: CW] = sum[SW-1:4];
        end
    end

    assign o_pix = pix;

endmodule

@@ hw/rtl/gb3_out.sv @@
module gb3_out (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  gb3_pkg::t_result [gb3_pkg::N_RES-1:0] i_res,
    input  logic [gb3_pkg::N_RES-1:0]            i_mask,
    output logic                                 o_free,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output gb3_pkg::t_result                     o_res,
    output logic                                 o_last
);

    localparam int NR = gb3_pkg::N_RES;

    gb3_pkg::t_result [NR-1:0] r_res;
    logic [NR-1:0]             r_mask;
    logic [NR-1:0]             n_mask;
    logic [NR-1:0]             sel;
    logic [NR-1:0]             rest;
    logic                      out_acc;

    always_comb begin
        sel   = '0;
        o_res = r_res[0];
        for (int k = NR - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel    = '0;
                sel[k] = 1'b1;
                o_res  = r_res[k];
            end
        end
    end

    assign rest    = r_mask & ~sel;
    assign o_valid = |r_mask;
    assign o_last  = (rest == '0);
    assign out_acc = o_valid && !i_stall;
    assign o_free  = !o_valid || (out_acc && o_last);

    always_comb begin
        n_mask = r_mask;
        if (out_acc) begin
            n_mask = rest;
        end
        if (i_load) begin
            n_mask = i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ hw/rtl/gaussian_blur_3x3_rgb.sv @@
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------------
// config   | i_cfg_we     | -            | i_cfg_index, i_cfg_data
// pixel in | i_in_valid   | o_in_stall   | i_in_red, i_in_green, i_in_blue
// result   | o_out_valid  | i_out_stall  | o_out_red/green/blue, o_out_row/column,
//          |              |              | o_last_in_run, o_frame_done
// One request per cycle is taken while o_in_stall is low. The single result port sets
// the rate: a request causing n results holds the input until all n are taken, so with
// no output stall rows 0 to H-2 run at one pixel per cycle save the last column of rows
// 1 to H-2 (two results); the last row is slower (mostly two, three at its end).
// Reset (synchronous, active low) restores 1024x768 and restarts at row 0, column 0;
// line stores are not cleared. A stall on the result side backs up through two stages.
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = gb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gb3_pkg::CHAN_W-1:0]        i_in_red,
    input  logic [gb3_pkg::CHAN_W-1:0]        i_in_green,
    input  logic [gb3_pkg::CHAN_W-1:0]        i_in_blue,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gb3_pkg::CHAN_W-1:0]        o_out_red,
    output logic [gb3_pkg::CHAN_W-1:0]        o_out_green,
    output logic [gb3_pkg::CHAN_W-1:0]        o_out_blue,
    output logic [gb3_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic [gb3_pkg::OUT_COL_W-1:0]     o_out_column,
    output logic                              o_last_in_run,
    output logic                              o_frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int ORW = gb3_pkg::OUT_ROW_W;
    localparam int OCW = gb3_pkg::OUT_COL_W;
    localparam int PW  = gb3_pkg::PIX_W;
    localparam int NR  = gb3_pkg::N_RES;
    localparam int MIN = gb3_pkg::MIN_DIM;
    localparam logic [WW-1:0] WIDTH_RST =
        WW'((gb3_pkg::IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : gb3_pkg::IMAGE_WIDTH_RST);
    localparam logic [HW-1:0] HEIGHT_RST =
        HW'((gb3_pkg::IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                     : gb3_pkg::IMAGE_HEIGHT_RST);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;
    logic [31:0]   cfg_w;
    logic [31:0]   cfg_h;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] col0;
    logic          restart;

    logic            r_s1_valid;
    gb3_pkg::t_pixel r_s1_px;
    logic [CW-1:0]   r_s1_col;
    logic [RW-1:0]   r_s1_row;

    gb3_pkg::t_pixel [5:0] r_win;
    gb3_pkg::t_pixel       cur_up;
    gb3_pkg::t_pixel       cur_mid;
    gb3_pkg::t_pixel       blur_pix;

    logic in_acc;
    logic s1_adv;
    logic out_free;

    gb3_pkg::t_result [NR-1:0] res;
    logic [NR-1:0]             mask;
    gb3_pkg::t_result          out_res;

    logic s1_row0;
    logic s1_col0;
    logic s1_col_last;
    logic s1_row_last;

    // configuration
    assign cfg_w = 32'(i_cfg_data[gb3_pkg::IMAGE_WIDTH_W-1:0]);
    assign cfg_h = 32'(i_cfg_data[gb3_pkg::IMAGE_HEIGHT_W-1:0]);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        restart  = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH: begin
                    n_width = (cfg_w < 32'(MIN)) ? WW'(MIN)
                            : (cfg_w > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w);
                    restart = 1'b1;
                end
                gb3_pkg::REG_IMAGE_HEIGHT: begin
                    n_height = (cfg_h < 32'(MIN)) ? HW'(MIN)
                             : (cfg_h > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_h);
                    restart  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // position counters
    assign col0 = (32'(r_col) >= 32'(r_width)) ? '0 : r_col;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (restart) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (32'(col0) + 32'd1 >= 32'(r_width)) begin
                n_col = '0;
                n_row = (32'(r_row) + 32'd1 >= 32'(r_height)) ? '0 : r_row + RW'(1);
            end else begin
                n_col = col0 + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px  <= '{red: i_in_red, green: i_in_green, blue: i_in_blue};
            r_s1_col <= col0;
            r_s1_row <= r_row;
        end
    end

    // line stores
    gb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (cur_mid),
        .i_re    (in_acc),
        .i_raddr (col0),
        .o_rdata (cur_up)
    );

    gb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (in_acc),
        .i_raddr (col0),
        .o_rdata (cur_mid)
    );

    // window: advance one column per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= cur_up;
            r_win[2] <= r_win[3];
            r_win[3] <= cur_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= r_s1_px;
        end
    end

    gb3_blur u_blur (
        .i_win (r_win),
        .i_cur ({r_s1_px, cur_mid, cur_up}),
        .o_pix (blur_pix)
    );

    // result set for the item in stage 1
    assign s1_row0     = (r_s1_row == '0);
    assign s1_col0     = (r_s1_col == '0);
    assign s1_col_last = (32'(r_s1_col) == 32'(r_width) - 32'd1);
    assign s1_row_last = (32'(r_s1_row) == 32'(r_height) - 32'd1);

    always_comb begin
        mask[0] = !s1_row0 && !s1_col0;
        mask[1] = !s1_row0 && s1_col_last;
        mask[2] = s1_row_last;

        res[0].pixel      = (r_s1_row == RW'(1) || r_s1_col == CW'(1)) ? r_win[3] : blur_pix;
        res[0].row        = ORW'(r_s1_row - RW'(1));
        res[0].column     = OCW'(r_s1_col - CW'(1));
        res[0].frame_done = 1'b0;

        res[1].pixel      = cur_mid;
        res[1].row        = ORW'(r_s1_row - RW'(1));
        res[1].column     = OCW'(r_s1_col);
        res[1].frame_done = 1'b0;

        res[2].pixel      = r_s1_px;
        res[2].row        = ORW'(r_s1_row);
        res[2].column     = OCW'(r_s1_col);
        res[2].frame_done = s1_col_last;
    end

    gb3_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_res   (res),
        .i_mask  (mask),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res),
        .o_last  (o_last_in_run)
    );

    assign o_out_red    = out_res.pixel.red;
    assign o_out_green  = out_res.pixel.green;
    assign o_out_blue   = out_res.pixel.blue;
    assign o_out_row    = out_res.row;
    assign o_out_column = out_res.column;
    assign o_frame_done = out_res.frame_done;

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gb3_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 480;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = CFG_INDEX_W'(3);

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;
    typedef enum int {PIX_RANDOM, PIX_FULL, PIX_CHECKER} t_pix_kind;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_expected_pixel;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [CHAN_W-1:0]      i_in_red = '0;
    logic [CHAN_W-1:0]      i_in_green = '0;
    logic [CHAN_W-1:0]      i_in_blue = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [CHAN_W-1:0]      o_out_red;
    logic [CHAN_W-1:0]      o_out_green;
    logic [CHAN_W-1:0]      o_out_blue;
    logic [OUT_ROW_W-1:0]   o_out_row;
    logic [OUT_COL_W-1:0]   o_out_column;
    logic                   o_last_in_run;
    logic                   o_frame_done;

    gaussian_blur_3x3_rgb dut (.*);

    // blur predictor state
    int unsigned     img_w = IMAGE_WIDTH_RST;
    int unsigned     img_h = IMAGE_HEIGHT_RST;
    int unsigned     pos_row = 0;
    int unsigned     pos_col = 0;
    logic [PIX_W-1:0] store_upper [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] store_middle [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [6];

    t_expected_pixel expected_pixels [$];
    t_expected_pixel head_px;

    t_stall_mode stall_mode = STALL_NONE;
    int          hold_cycles = 0;
    bit          sender_bursty = 1'b0;
    int          burst_left = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int n_pixels = 0;
    int n_results = 0;
    int n_frames = 0;
    int n_cfg = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: long hold first, otherwise the selected stall pattern
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
                default:      i_out_stall <= ((cycle_count % 11) < 4);
            endcase
        end
    end

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got, input int unsigned row,
                                        input int unsigned col);
        if (want != got) begin
            $display("%0t: pixel (%0d,%0d) %s expected %0d actual %0d",
                     $time, row, col, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result (%0d,%0d) with nothing pending", $time,
                         o_out_row, o_out_column);
                mismatches++;
            end else begin
                head_px = expected_pixels.pop_front();
                check_field("red", head_px.res.pixel.red, o_out_red,
                            head_px.res.row, head_px.res.column);
                check_field("green", head_px.res.pixel.green, o_out_green,
                            head_px.res.row, head_px.res.column);
                check_field("blue", head_px.res.pixel.blue, o_out_blue,
                            head_px.res.row, head_px.res.column);
                check_field("row", head_px.res.row, o_out_row,
                            head_px.res.row, head_px.res.column);
                check_field("column", head_px.res.column, o_out_column,
                            head_px.res.row, head_px.res.column);
                check_field("last_in_run", head_px.last, o_last_in_run,
                            head_px.res.row, head_px.res.column);
                check_field("frame_done", head_px.res.frame_done, o_frame_done,
                            head_px.res.row, head_px.res.column);
                n_results++;
                if (head_px.res.frame_done) n_frames++;
            end
        end
    end

    function automatic t_expected_pixel make_expected(input logic [PIX_W-1:0] pix,
                                                      input int unsigned row,
                                                      input int unsigned col);
        t_expected_pixel e;
        e.res.pixel      = pix;
        e.res.row        = OUT_ROW_W'(row);
        e.res.column     = OUT_COL_W'(col);
        e.res.frame_done = (row == img_h - 1) && (col == img_w - 1);
        e.last           = 1'b0;
        return e;
    endfunction

    function automatic logic [PIX_W-1:0] blur3(input logic [PIX_W-1:0] up,
                                               input logic [PIX_W-1:0] mid,
                                               input logic [PIX_W-1:0] cur);
        logic [PIX_W-1:0] res;
        int unsigned      sum;
        int               sh;
        for (sh = 0; sh <= 16; sh += 8) begin
            sum = win[0][sh +: 8] + 2 * win[1][sh +: 8] + up[sh +: 8]
                + 2 * (win[2][sh +: 8] + 2 * win[3][sh +: 8] + mid[sh +: 8])
                + win[4][sh +: 8] + 2 * win[5][sh +: 8] + cur[sh +: 8];
            res[sh +: 8] = 8'(sum >> 4);
        end
        return res;
    endfunction

    function automatic void predict_blur(input logic [PIX_W-1:0] px);
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
        t_expected_pixel  res [3];
        int               n;
        int               i;
        r = pos_row;
        c = pos_col;
        n = 0;
        if (c >= img_w || c >= MAX_WIDTH_DEF) c = 0;
        up  = store_upper[c];
        mid = store_middle[c];
        if (r >= 1) begin
            if (c >= 1) begin
                pix = (r == 1 || c == 1) ? win[3] : blur3(up, mid, px);
                res[n] = make_expected(pix, r - 1, c - 1);
                n++;
            end
            if (c == img_w - 1) begin
                res[n] = make_expected(mid, r - 1, c);
                n++;
            end
        end
        if (r == img_h - 1) begin
            res[n] = make_expected(px, r, c);
            n++;
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (i = 0; i < n; i++) expected_pixels = {expected_pixels, res[i]};

        store_upper[c]  = mid;
        store_middle[c] = px;
        win[0] = win[1];
        win[1] = up;
        win[2] = win[3];
        win[3] = mid;
        win[4] = win[5];
        win[5] = px;

        if (c + 1 >= img_w) begin
            pos_col = 0;
            pos_row = (r + 1 >= img_h) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
        n_pixels++;
    endfunction

    function automatic void update_config(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        if (idx == REG_IMAGE_WIDTH) begin
            v = data[IMAGE_WIDTH_W-1:0];
            img_w = (v < MIN_DIM) ? MIN_DIM : (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
        end else if (idx == REG_IMAGE_HEIGHT) begin
            v = data[IMAGE_HEIGHT_W-1:0];
            img_h = (v < MIN_DIM) ? MIN_DIM : (v > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : v;
        end else begin
            return;
        end
        pos_row = 0;
        pos_col = 0;
    endfunction

    function automatic logic [PIX_W-1:0] make_pixel(input t_pix_kind kind, input int k);
        logic [PIX_W-1:0] p;
        int               ch;
        p = '0;
        case (kind)
            PIX_FULL:    p = '1;
            PIX_CHECKER: p = k[0] ? '1 : '0;
            default: begin
                for (ch = 0; ch < 3; ch++) begin
                    case ($urandom_range(0, 7))
                        0:       p[ch*8 +: 8] = 8'h00;
                        1:       p[ch*8 +: 8] = 8'hFF;
                        default: p[ch*8 +: 8] = 8'($urandom);
                    endcase
                end
            end
        endcase
        return p;
    endfunction

    // Call at a rising edge; returns at the edge that accepted the request.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (sender_bursty) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_red   <= px[23:16];
        i_in_green <= px[15:8];
        i_in_blue  <= px[7:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_blur(px);
    endtask

    task automatic send_pixels(input int count, input t_pix_kind kind);
        int k;
        for (k = 0; k < count; k++) send_pixel(make_pixel(kind, k));
    endtask

    task automatic send_frames(input int frames, input t_pix_kind kind);
        send_pixels(frames * img_w * img_h, kind);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_all_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        update_config(idx, data);
        n_cfg++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_dims();
        sender_bursty = 1'b1;
        stall_mode    = STALL_PATTERN;
        send_pixels(IMAGE_WIDTH_RST + 4, PIX_RANDOM);
        // height stays at its reset value
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(MIN_DIM));
        sender_bursty = 1'b0;
        stall_mode    = STALL_NONE;
        send_frames(1, PIX_RANDOM);
        send_pixels(2 * MIN_DIM + 1, PIX_RANDOM);
    endtask

    task automatic test_directed_patterns();
        sender_bursty = 1'b1;
        stall_mode    = STALL_RANDOM;
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(MIN_DIM));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
        send_frames(1, PIX_FULL);
        send_frames(1, PIX_CHECKER);
    endtask

    task automatic test_saturation();
        sender_bursty = 1'b0;
        stall_mode    = STALL_RANDOM;
        cfg_write(REG_IMAGE_WIDTH, '1);
        cfg_write(REG_IMAGE_HEIGHT, '0);
        send_frames(1, PIX_RANDOM);
        stall_mode = STALL_NONE;
        cfg_write(REG_IMAGE_WIDTH, {2'b11, 11'd2});
        cfg_write(REG_IMAGE_HEIGHT, '1);
        send_frames(1, PIX_RANDOM);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH_DEF + 1));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT_DEF + 1));
        send_pixels(2 * MAX_WIDTH_DEF + 8, PIX_RANDOM);
        stall_mode = STALL_PATTERN;
        cfg_write(REG_IMAGE_WIDTH, {2'b10, 11'd0});
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        send_frames(1, PIX_RANDOM);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        send_frames(2, PIX_RANDOM);
    endtask

    task automatic test_unmapped_index();
        sender_bursty = 1'b1;
        stall_mode    = STALL_RANDOM;
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        send_pixels(8, PIX_RANDOM);
        // frame position must survive these writes
        cfg_write(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
        cfg_write(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
        send_pixels(12, PIX_RANDOM);
        send_frames(1, PIX_RANDOM);
    endtask

    task automatic test_restart();
        sender_bursty = 1'b0;
        stall_mode    = STALL_PATTERN;
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        send_pixels(9, PIX_RANDOM);
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        send_frames(2, PIX_RANDOM);
    endtask

    task automatic test_backpressure();
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(8));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(6));
        sender_bursty = 1'b0;
        stall_mode    = STALL_NONE;
        hold_cycles   = 300;
        send_frames(2, PIX_RANDOM);
    endtask

    task automatic test_random_frames();
        int                    sent;
        int                    count;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       wdata = {2'($urandom), 11'($urandom_range(0, 2))};
                1, 2:    wdata = CFG_DATA_W'($urandom_range(11, 40));
                default: wdata = CFG_DATA_W'($urandom_range(3, 10));
            endcase
            if ($urandom_range(0, 9) == 0) hdata = CFG_DATA_W'($urandom_range(0, 2));
            else hdata = CFG_DATA_W'($urandom_range(3, 8));
            sender_bursty = $urandom_range(0, 1);
            stall_mode    = t_stall_mode'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_IMAGE_WIDTH, wdata);
                cfg_write(REG_IMAGE_HEIGHT, hdata);
            end else begin
                cfg_write(REG_IMAGE_HEIGHT, hdata);
                cfg_write(REG_IMAGE_WIDTH, wdata);
            end
            // mostly whole frames; some are cut short by the next write
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, img_w * img_h - 1);
            else count = $urandom_range(1, 2) * img_w * img_h;
            send_pixels(count, PIX_RANDOM);
            sent += count;
        end
    endtask

    initial begin
        foreach (store_upper[i]) begin
            store_upper[i]  = '0;
            store_middle[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_dims();
        test_directed_patterns();
        test_saturation();
        test_unmapped_index();
        test_restart();
        test_backpressure();
        test_random_frames();
        wait_all_results();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d pixels over %0d register writes, checked %0d results",
                 n_pixels, n_cfg, n_results);
        $display("Completed %0d frames, from 3x3 up to 1024 wide and 4096 high", n_frames);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
